// ===== rtl/drt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dirty rectangle tracker
// Table geometry, coordinate widths, register indexes and the rectangle type.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int MAX_RECTS = 32;
  localparam int MAX_DIM   = 4096;

  localparam int IDX_W   = $clog2(MAX_RECTS);
  localparam int CNT_W   = $clog2(MAX_RECTS + 1);
  localparam int COORD_W = 13;
  localparam int FIELD_W = 16;

  localparam int IN_DATA_W  = 4 * FIELD_W;
  localparam int RECT_W     = 4 * COORD_W;
  localparam int OUT_DATA_W = ((RECT_W + 7) / 8) * 8;

  localparam logic [COORD_W-1:0] SCREEN_W_RST = COORD_W'(1024);
  localparam logic [COORD_W-1:0] SCREEN_H_RST = COORD_W'(768);

  // configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // input commands
  localparam logic CMD_MARK    = 1'b0;
  localparam logic CMD_PRESENT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x0;
  } rect_t;

endpackage : drt_pkg
`default_nettype wire

// ===== rtl/dirty_rectangle_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker: table of screen regions waiting to be redrawn
//
// in_*  : one transaction per command. in_tuser = command (0 mark, 1 present),
//         in_tdata = left, top, span_w, span_h (signed 16 bit each).
// out_* : one transaction per stored rectangle on present, x0/y0 inclusive,
//         x1/y1 exclusive, out_tlast on the final rectangle of the run.
// cfg_* : screen_width (index 0), screen_height (index 1), write-only.
//
// A mark is clipped in the clip state, then one compare/merge unit walks the
// table entry by entry through a RAM with one write port and a registered
// read port: an entry that does not touch is read and compared; a merged
// entry is filled with the last entry, which is read and moved into the hole
// (a hit on the last entry just drops it), and the walk restarts at entry 0
// after every merge. A present reads the rectangles one by one; the output
// register holds a result while out_tready is low and the sequencer waits for
// it, and the next rectangle is read while the last one is held.
// in_tready is high only while the sequencer is idle.
// Reset empties the table (the RAM itself is not cleared) and sets the
// screen to 1024 x 768. An empty present gives no transaction.
// ----------------------------------------------------------------------------
module dirty_rectangle_tracker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [drt_pkg::IN_DATA_W-1:0]    in_tdata,   // left, top, span_w, span_h
  input  wire  [0:0]                       in_tuser,   // command
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [drt_pkg::OUT_DATA_W-1:0]   out_tdata,  // rect_x0, rect_y0, rect_x1, rect_y1
  output logic                             out_tlast,  // last
  input  wire                              cfg_we,
  input  wire  [0:0]                       cfg_idx,
  input  wire  [drt_pkg::COORD_W-1:0]      cfg_wdata
);
  import drt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLIP, ST_SCAN_RD, ST_SCAN_CMP, ST_MOVE_RD, ST_MOVE_WR,
    ST_FINISH, ST_PRES_RD, ST_PRES_LD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  rect_t               nb_r, nb_nxt;
  logic [FIELD_W-1:0]  left_r, top_r, span_w_r, span_h_r;
  logic [COORD_W-1:0]  scr_w_r, scr_h_r;
  rect_t               out_rect_r, out_rect_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_last_r, out_last_nxt;

  // table RAM
  rect_t               mem [MAX_RECTS];
  rect_t               mem_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  rect_t               mem_wdata;

  logic [COORD_W-1:0]  sw_eff, sh_eff;
  logic [CNT_W-1:0]    cnt_m1;
  logic                in_acc;

  // clip
  logic signed [FIELD_W:0] x1_s, y1_s, x1_c, y1_c, x0_c, y0_c, sw_s, sh_s;
  logic                    drop;

  // merge unit
  logic  meet;
  rect_t merged;

  assign in_acc = in_tvalid && in_tready;
  assign cnt_m1 = cnt_r - CNT_W'(1);

  assign sw_eff = (scr_w_r > COORD_W'(MAX_DIM)) ? COORD_W'(MAX_DIM) : scr_w_r;
  assign sh_eff = (scr_h_r > COORD_W'(MAX_DIM)) ? COORD_W'(MAX_DIM) : scr_h_r;

  always_comb begin
    sw_s = signed'({{(FIELD_W + 1 - COORD_W){1'b0}}, sw_eff});
    sh_s = signed'({{(FIELD_W + 1 - COORD_W){1'b0}}, sh_eff});
    x1_s = signed'({left_r[FIELD_W-1], left_r}) + signed'({span_w_r[FIELD_W-1], span_w_r});
    y1_s = signed'({top_r[FIELD_W-1], top_r}) + signed'({span_h_r[FIELD_W-1], span_h_r});
    x1_c = (x1_s > sw_s) ? sw_s : x1_s;
    y1_c = (y1_s > sh_s) ? sh_s : y1_s;
    x0_c = left_r[FIELD_W-1] ? '0 : signed'({1'b0, left_r});
    y0_c = top_r[FIELD_W-1]  ? '0 : signed'({1'b0, top_r});
    drop = span_w_r[FIELD_W-1] || (span_w_r == '0) ||
           span_h_r[FIELD_W-1] || (span_h_r == '0) ||
           (x0_c >= x1_c) || (y0_c >= y1_c);
  end

  // edges count as touching
  always_comb begin
    meet = (nb_r.x0 <= mem_q.x1) && (nb_r.x1 >= mem_q.x0) &&
           (nb_r.y0 <= mem_q.y1) && (nb_r.y1 >= mem_q.y0);
    merged.x0 = (mem_q.x0 < nb_r.x0) ? mem_q.x0 : nb_r.x0;
    merged.y0 = (mem_q.y0 < nb_r.y0) ? mem_q.y0 : nb_r.y0;
    merged.x1 = (mem_q.x1 > nb_r.x1) ? mem_q.x1 : nb_r.x1;
    merged.y1 = (mem_q.y1 > nb_r.y1) ? mem_q.y1 : nb_r.y1;
  end

  assign rd_addr = (state_r == ST_MOVE_RD) ? cnt_m1[IDX_W-1:0] : idx_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    nb_nxt        = nb_r;
    out_rect_nxt  = out_rect_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IDX_W-1:0];
    mem_wdata     = nb_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          if (in_tuser[0] == CMD_PRESENT) begin
            if (cnt_r != '0) state_nxt = ST_PRES_RD;
          end else begin
            state_nxt = ST_CLIP;
          end
        end
      end
      ST_CLIP: begin
        nb_nxt.x0 = x0_c[COORD_W-1:0];
        nb_nxt.y0 = y0_c[COORD_W-1:0];
        nb_nxt.x1 = x1_c[COORD_W-1:0];
        nb_nxt.y1 = y1_c[COORD_W-1:0];
        state_nxt = drop ? ST_IDLE : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_nxt = (idx_r == cnt_r) ? ST_FINISH : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (meet) begin
          nb_nxt = merged;
          if (idx_r == cnt_m1) begin
            // hit on the last entry: just drop it
            cnt_nxt   = cnt_m1;
            idx_nxt   = '0;
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_MOVE_RD;
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_MOVE_RD: begin
        state_nxt = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_q;
        cnt_nxt   = cnt_m1;
        idx_nxt   = '0;
        state_nxt = ST_SCAN_RD;
      end
      ST_FINISH: begin
        mem_we = 1'b1;
        if (cnt_r == CNT_W'(MAX_RECTS)) begin
          // table full: collapse to the whole screen
          mem_waddr    = '0;
          mem_wdata.x0 = '0;
          mem_wdata.y0 = '0;
          mem_wdata.x1 = sw_eff;
          mem_wdata.y1 = sh_eff;
          cnt_nxt      = CNT_W'(1);
        end else begin
          mem_waddr = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_PRES_RD: begin
        state_nxt = ST_PRES_LD;
      end
      ST_PRES_LD: begin
        if (!out_valid_r || out_tready) begin
          out_rect_nxt  = mem_q;
          out_last_nxt  = (idx_r == cnt_m1);
          out_valid_nxt = 1'b1;
          if (idx_r == cnt_m1) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_PRES_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      scr_w_r     <= SCREEN_W_RST;
      scr_h_r     <= SCREEN_H_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    nb_r       <= nb_nxt;
    out_rect_r <= out_rect_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      left_r   <= in_tdata[FIELD_W-1:0];
      top_r    <= in_tdata[2*FIELD_W-1:FIELD_W];
      span_w_r <= in_tdata[3*FIELD_W-1:2*FIELD_W];
      span_h_r <= in_tdata[4*FIELD_W-1:3*FIELD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[rd_addr];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - RECT_W){1'b0}}, out_rect_r};

endmodule : dirty_rectangle_tracker
`default_nettype wire

// ===== rtl/drt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drt_assertions: port-level checks of the dirty rectangle tracker
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module drt_assertions (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire  [0:0]                       in_tuser,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire  [drt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire                              out_tlast
);
  import drt_pkg::*;

  rect_t out_rect;
  assign out_rect = out_tdata[RECT_W-1:0];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a mark keeps the sequencer busy in the cycle after it is accepted
  a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == CMD_MARK) |=> !in_tready)
    else $error("ready right after a mark transaction");

  // a mark never starts a result
  a_mark_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == CMD_MARK) && !out_tvalid |=> !out_tvalid)
    else $error("result after a mark transaction");

  a_rect_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_rect.x0 <= out_rect.x1) && (out_rect.y0 <= out_rect.y1))
    else $error("rectangle edges out of order");

endmodule : drt_assertions

bind dirty_rectangle_tracker drt_assertions u_drt_assertions (.*);
`default_nettype wire
